@@ rtl/c3f_pkg.sv @@
// ----------------------------------------------------------------------------
// c3f_pkg
// Shared types and constants of the 3x3 image filter.
// ----------------------------------------------------------------------------
`default_nettype none

package c3f_pkg;

  localparam int PIX_W         = 8;
  localparam int COEF_W        = 16;
  localparam int KDIM          = 3;
  localparam int TAPS          = KDIM * KDIM;
  localparam int FRAC_BITS     = 12;
  localparam int ROW_W         = 12;
  localparam int IMG_W_BITS    = 12;
  localparam int IMG_H_BITS    = 13;
  localparam int MAX_HEIGHT    = 4096;
  localparam int MAX_WIDTH_DEF = 2048;
  localparam int COEF_ROW_W    = KDIM * COEF_W;

  localparam int QUEUE_DEPTH = 4;
  localparam int QAW         = $clog2(QUEUE_DEPTH);
  localparam int QLW         = QAW + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEF_ROW_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_TOP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_MID     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_BOT     = 3'd4;

  // reset values: 1-2-1 / 2-4-2 / 1-2-1 over 16 in Q4.12
  localparam logic [IMG_W_BITS-1:0] RST_IMAGE_WIDTH  = 12'd640;
  localparam logic [IMG_H_BITS-1:0] RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [COEF_ROW_W-1:0] RST_COEF_EDGE    = 48'h0100_0200_0100;
  localparam logic [COEF_ROW_W-1:0] RST_COEF_CENTER  = 48'h0200_0400_0200;

  typedef logic [KDIM-1:0][COEF_ROW_W-1:0] c3f_coefs_t;

  typedef struct packed {
    logic [IMG_W_BITS-1:0] width;
    logic [IMG_H_BITS-1:0] height;
  } c3f_geom_t;

  // one window to filter; pix[ky*3+kx]
  typedef struct packed {
    logic [TAPS-1:0][PIX_W-1:0] pix;
    logic                       last;
  } c3f_job_t;

  typedef struct packed {
    logic [QLW-1:0] level;
    logic           empty;
  } c3f_qstat_t;

endpackage

`default_nettype wire

@@ rtl/c3f_front.sv @@
// ----------------------------------------------------------------------------
// c3f_front
// Pixel intake: position counters, line stores, 3x3 window, job issue.
// ----------------------------------------------------------------------------
`default_nettype none

module c3f_front #(
  parameter int MAX_WIDTH = c3f_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire c3f_pkg::c3f_geom_t       geom,
  input  wire logic                     in_tvalid,
  output logic                          in_tready,
  input  wire logic [c3f_pkg::PIX_W-1:0] in_pix,
  input  wire logic                     in_sof,
  input  wire c3f_pkg::c3f_qstat_t      qstat,
  output logic                          push,
  output c3f_pkg::c3f_job_t             push_job
);
  import c3f_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int LW = (CW + 1 > IMG_W_BITS) ? CW + 1 : IMG_W_BITS;

  logic accept;

  // effective geometry
  logic [LW-1:0]         w_raw;
  logic [LW-1:0]         w_sat;
  logic [CW:0]           weff;
  logic [IMG_H_BITS-1:0] heff;

  assign w_raw = LW'(geom.width);
  assign w_sat = (w_raw < LW'(3)) ? LW'(3) :
                 (w_raw > LW'(MAX_WIDTH)) ? LW'(MAX_WIDTH) : w_raw;
  assign weff  = w_sat[CW:0];
  assign heff  = (geom.height < IMG_H_BITS'(3)) ? IMG_H_BITS'(3) :
                 (geom.height > IMG_H_BITS'(MAX_HEIGHT)) ? IMG_H_BITS'(MAX_HEIGHT) :
                 geom.height;

  // position counters
  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CW-1:0]    col_base, c_cur;
  logic [ROW_W-1:0] row_base, r_cur;
  logic [ROW_W:0]   r_inc, r_plus;
  logic             wrap_c;
  logic             emit, last;

  always_comb begin
    col_base = in_sof ? '0 : col_r;
    row_base = in_sof ? '0 : row_r;
    wrap_c   = ({1'b0, col_base} >= weff);
    c_cur    = wrap_c ? '0 : col_base;
    r_inc    = {1'b0, row_base} + (ROW_W+1)'(wrap_c);
    r_cur    = (r_inc >= (ROW_W+1)'(heff)) ? '0 : r_inc[ROW_W-1:0];
    r_plus   = {1'b0, r_cur} + (ROW_W+1)'(1);
    if (({1'b0, c_cur} + (CW+1)'(1)) >= weff) begin
      col_nxt = '0;
      row_nxt = (r_plus >= (ROW_W+1)'(heff)) ? '0 : r_plus[ROW_W-1:0];
    end else begin
      col_nxt = c_cur + CW'(1);
      row_nxt = r_cur;
    end
    emit = (r_cur >= ROW_W'(2)) && (c_cur >= CW'(2));
    last = ((ROW_W+1)'(r_cur) == (ROW_W+1)'(heff - IMG_H_BITS'(1))) &&
           ({1'b0, c_cur} == (weff - (CW+1)'(1)));
  end

  // read stage
  logic             a_valid_r;
  logic [PIX_W-1:0] a_pix_r;
  logic [CW-1:0]    a_col_r;
  logic             a_emit_r, a_last_r;
  logic             hit_r;
  logic [PIX_W-1:0] byp_up_r, byp_mid_r;
  logic [PIX_W-1:0] up_q_r, mid_q_r;
  logic [PIX_W-1:0] up_val, mid_val;

  logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

  // room for this pixel and the one ahead of it
  assign in_tready = (qstat.level + QLW'(a_valid_r)) < QLW'(QUEUE_DEPTH);
  assign accept    = in_tvalid && in_tready;

  // an entry written by the previous pixel is forwarded
  assign up_val  = hit_r ? byp_up_r  : up_q_r;
  assign mid_val = hit_r ? byp_mid_r : mid_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      a_valid_r <= 1'b0;
      hit_r     <= 1'b0;
    end else begin
      a_valid_r <= accept;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        hit_r <= a_valid_r && (a_col_r == c_cur);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_pix_r   <= in_pix;
      a_col_r   <= c_cur;
      a_emit_r  <= emit;
      a_last_r  <= last;
      up_q_r    <= upper_mem[c_cur];
      mid_q_r   <= middle_mem[c_cur];
      byp_up_r  <= mid_val;
      byp_mid_r <= a_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid_r) begin
      upper_mem[a_col_r]  <= mid_val;
      middle_mem[a_col_r] <= a_pix_r;
    end
  end

  // window: win_r[0..2] column c-2, win_r[3..5] column c-1 (top, mid, bottom)
  logic [5:0][PIX_W-1:0] win_r;
  logic [KDIM-1:0][PIX_W-1:0] col_now;

  assign col_now = {a_pix_r, mid_val, up_val};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (a_valid_r) begin
      win_r[2:0] <= win_r[5:3];
      win_r[5:3] <= col_now;
    end
  end

  always_comb begin
    for (int ky = 0; ky < KDIM; ky++) begin
      push_job.pix[ky*KDIM + 0] = win_r[ky];
      push_job.pix[ky*KDIM + 1] = win_r[KDIM + ky];
      push_job.pix[ky*KDIM + 2] = col_now[ky];
    end
    push_job.last = a_last_r;
  end

  assign push = a_valid_r && a_emit_r;

  // interior results never come from the first two columns
  a_emit_col : assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (a_col_r >= CW'(2)))
    else $error("job issued for a border column");

endmodule

`default_nettype wire

@@ rtl/c3f_queue.sv @@
// ----------------------------------------------------------------------------
// c3f_queue
// Short job queue between intake and arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module c3f_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire c3f_pkg::c3f_job_t   push_job,
  input  wire logic                pop,
  output c3f_pkg::c3f_job_t        pop_job,
  output c3f_pkg::c3f_qstat_t      qstat
);
  import c3f_pkg::*;

  c3f_job_t       slot_r [QUEUE_DEPTH];
  logic [QAW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QLW-1:0] level_r, level_nxt;

  always_comb begin
    level_nxt = level_r;
    if (push && !pop) level_nxt = level_r + QLW'(1);
    if (pop && !push) level_nxt = level_r - QLW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      level_r  <= '0;
    end else begin
      level_r <= level_nxt;
      if (push) wr_ptr_r <= wr_ptr_r + QAW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QAW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_job;
  end

  assign pop_job     = slot_r[rd_ptr_r];
  assign qstat.level = level_r;
  assign qstat.empty = (level_r == '0);

  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (level_r < QLW'(QUEUE_DEPTH)))
    else $error("queue overflow");

  a_no_underflow : assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (level_r != '0))
    else $error("queue underflow");

  a_level_hold : assert property (@(posedge clk) disable iff (!rst_n)
    (!push && !pop) |=> $stable(level_r))
    else $error("queue level moved without push or pop");

endmodule

`default_nettype wire

@@ rtl/c3f_back.sv @@
// ----------------------------------------------------------------------------
// c3f_back
// Nine-tap multiply, adder tree, truncate and clamp, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module c3f_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire c3f_pkg::c3f_coefs_t         coefs,
  input  wire c3f_pkg::c3f_qstat_t         qstat,
  input  wire c3f_pkg::c3f_job_t           job,
  output logic                             pop,
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [c3f_pkg::PIX_W-1:0]        out_pix,
  output logic                             out_last
);
  import c3f_pkg::*;

  localparam int PROD_W = PIX_W + 1 + COEF_W;
  localparam int PS_W   = PROD_W + 2;
  localparam int SUM_W  = PS_W + 2;
  localparam int HI_W   = SUM_W - FRAC_BITS;

  logic advance;
  assign advance = !out_tvalid || out_tready;
  assign pop     = advance && !qstat.empty;

  // stage 1: products
  logic                            p_valid_r, p_last_r;
  logic signed [TAPS-1:0][PROD_W-1:0] prod_r;
  // stage 2: row sums
  logic                            s_valid_r, s_last_r;
  logic signed [KDIM-1:0][PS_W-1:0] ps_r;

  logic signed [SUM_W-1:0]   total;
  logic        [HI_W-1:0]    hi;
  logic        [PIX_W-1:0]   clamped;

  // elements of a packed array are unsigned; sign-extend explicitly
  always_comb begin
    total = SUM_W'($signed(ps_r[0])) + SUM_W'($signed(ps_r[1])) +
            SUM_W'($signed(ps_r[2]));
    hi    = total[SUM_W-1:FRAC_BITS];
    if (total[SUM_W-1] || (total == '0)) begin
      clamped = '0;
    end else if (hi > HI_W'(255)) begin
      clamped = '1;
    end else begin
      clamped = hi[PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r  <= 1'b0;
      s_valid_r  <= 1'b0;
      out_tvalid <= 1'b0;
    end else if (advance) begin
      p_valid_r  <= pop;
      s_valid_r  <= p_valid_r;
      out_tvalid <= s_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int ky = 0; ky < KDIM; ky++) begin
        for (int kx = 0; kx < KDIM; kx++) begin
          prod_r[ky*KDIM + kx] <= $signed({1'b0, job.pix[ky*KDIM + kx]}) *
                                  $signed(coefs[ky][COEF_W*kx +: COEF_W]);
        end
        ps_r[ky] <= PS_W'($signed(prod_r[ky*KDIM])) +
                    PS_W'($signed(prod_r[ky*KDIM + 1])) +
                    PS_W'($signed(prod_r[ky*KDIM + 2]));
      end
      p_last_r <= job.last;
      s_last_r <= p_last_r;
      out_pix  <= clamped;
      out_last <= s_last_r;
    end
  end

  a_out_from_pipe : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(s_valid_r))
    else $error("result appeared without a job in the sum stage");

endmodule

`default_nettype wire

@@ rtl/conv3x3_image_filter.sv @@
// ----------------------------------------------------------------------------
// conv3x3_image_filter
// 3x3 grayscale filter over a raster pixel stream with Q4.12 coefficients.
// ----------------------------------------------------------------------------
// Takes one 8-bit pixel per clock unless stalled and emits one filtered pixel
// for every interior centre position (row and column of the arriving pixel
// both at least 2); border positions give nothing. in_tuser marks the first
// pixel of a frame and resets the position counters; out_tlast marks the
// result for the last interior centre. Counters also wrap by themselves at
// the end of a frame. On its way to out_tvalid a pixel gets the line store
// read at the accept edge, then window/issue, product, row sums and final sum
// with clamp. The one-pixel-per-clock figure is set by the two line stores,
// each read and written once per pixel, and by the three-stage multiply
// pipeline, taking one job per clock unless stalled. A four-entry job queue
// parts intake from the arithmetic; in_tready drops only when output
// back-pressure leaves it no room for the read-stage pixel and one more. No
// clearing pass runs after reset: line store contents are unknown until the
// first two rows of a frame have been written. Write configuration only
// while the stream is idle; this is not enforced. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module conv3x3_image_filter #(
  parameter int MAX_WIDTH = c3f_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // pixel input
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [7:0]                     in_tdata,   // [7:0] pixel_in
  input  wire logic                           in_tuser,   // [0] frame_start
  // filtered output
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [7:0]                          out_tdata,  // [7:0] pixel_out
  output logic                                out_tlast,  // frame_end
  // register writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [c3f_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [c3f_pkg::CFG_DATA_W-1:0] cfg_data
);
  import c3f_pkg::*;

  // configuration registers
  logic [IMG_W_BITS-1:0] image_width_r;
  logic [IMG_H_BITS-1:0] image_height_r;
  c3f_coefs_t            coefs_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= RST_IMAGE_WIDTH;
      image_height_r <= RST_IMAGE_HEIGHT;
      coefs_r[0]     <= RST_COEF_EDGE;
      coefs_r[1]     <= RST_COEF_CENTER;
      coefs_r[2]     <= RST_COEF_EDGE;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_data[IMG_W_BITS-1:0];
        REG_IMAGE_HEIGHT: image_height_r <= cfg_data[IMG_H_BITS-1:0];
        REG_COEF_TOP:     coefs_r[0]     <= cfg_data;
        REG_COEF_MID:     coefs_r[1]     <= cfg_data;
        REG_COEF_BOT:     coefs_r[2]     <= cfg_data;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  c3f_geom_t geom;
  assign geom.width  = image_width_r;
  assign geom.height = image_height_r;

  // front: counters, line stores, window -> jobs
  c3f_qstat_t qstat;
  c3f_job_t   push_job, pop_job;
  logic       push, pop;

  c3f_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .geom      (geom),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_pix    (in_tdata),
    .in_sof    (in_tuser),
    .qstat     (qstat),
    .push      (push),
    .push_job  (push_job)
  );

  c3f_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .qstat    (qstat)
  );

  // back: nine taps, sum, truncate toward zero, clamp 0..255
  c3f_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .coefs      (coefs_r),
    .qstat      (qstat),
    .job        (pop_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_pix    (out_tdata),
    .out_last   (out_tlast)
  );

endmodule

`default_nettype wire

@@ sim/conv3x3_image_filter_tb.sv @@
// ----------------------------------------------------------------------------
// conv3x3_image_filter_tb
// Self-checking bench for the 3x3 image filter.
// ----------------------------------------------------------------------------
// Streams raster pixels into the filter and tracks the line stores, the
// window and the position counters in a local copy. Every accepted pixel
// request updates that copy and may queue one expected filtered pixel. The
// checker pops one expectation per accepted output request and compares
// pixel and frame_end separately. Registers are rewritten only after the
// stream has drained. Tests: a directed frame pair, a mid-frame geometry
// shrink, saturated extreme geometry, then random frames with gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module conv3x3_image_filter_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import c3f_pkg::*;

  // margin for the filter pipe to settle before touching registers
  localparam int unsigned SETTLE_CYCLES = 12;
  // receiver hold-off, long enough to fill the job queue and the pipe
  localparam int unsigned LONG_HOLD = 200;
  // overall run limit, many times the slowest legal run
  localparam longint RUN_LIMIT_NS = 10_000_000;
  localparam int unsigned RANDOM_ITEMS = 500;
  // pixels sent under the widest and under the tallest saturated geometry
  localparam int unsigned WIDE_PIXELS = 48;
  localparam int unsigned TALL_PIXELS = 20 * KDIM;

  typedef enum int {
    KERN_SMOOTH,
    KERN_SIGNED,
    KERN_FULL,
    KERN_EXTREME
  } kern_style_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
  } filt_pix_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [7:0]            out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // stimulus controls (rx ones shared with the ready driver), error count
  bit          tx_gaps_on;
  bit          rx_gaps_on;
  int unsigned hold_requests;
  int unsigned n_errors;

  // expected filtered pixels, oldest first
  filt_pix_t expected_pix[$];

  // local copy of the filter state and its registers
  logic [IMG_W_BITS-1:0] geo_width;
  logic [IMG_H_BITS-1:0] geo_height;
  logic [COEF_ROW_W-1:0] kern_row [KDIM];
  logic [PIX_W-1:0]      line_two_up [MAX_WIDTH_DEF];
  logic [PIX_W-1:0]      line_one_up [MAX_WIDTH_DEF];
  logic [PIX_W-1:0]      win_pix [2*KDIM];   // 0..2 column c-2, 3..5 column c-1
  int unsigned           col_at;
  int unsigned           row_at;

  conv3x3_image_filter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // State copy
  // --------------------------------------------------------------------------
  function automatic void model_reset();
    geo_width   = RST_IMAGE_WIDTH;
    geo_height  = RST_IMAGE_HEIGHT;
    kern_row[0] = RST_COEF_EDGE;
    kern_row[1] = RST_COEF_CENTER;
    kern_row[2] = RST_COEF_EDGE;
    foreach (line_two_up[i]) line_two_up[i] = '0;
    foreach (line_one_up[i]) line_one_up[i] = '0;
    foreach (win_pix[i]) win_pix[i] = '0;
    col_at = 0;
    row_at = 0;
  endfunction

  // One accepted pixel: advance the counters, maybe queue a filtered value,
  // then shift the window and the line stores.
  function automatic void predict_filtered(input logic [PIX_W-1:0] px, input logic fs);
    int unsigned w, h, c, r;
    int          ky, kx;
    logic [PIX_W-1:0] column [KDIM];
    logic [PIX_W-1:0] p;
    shortint     k;
    longint      acc;
    filt_pix_t   res;
    w = geo_width;
    h = geo_height;
    if (w < KDIM) w = KDIM;
    if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
    if (h < KDIM) h = KDIM;
    if (h > MAX_HEIGHT) h = MAX_HEIGHT;

    if (fs) begin
      col_at = 0;
      row_at = 0;
    end
    // counters can sit past the geometry after a register shrink
    if (col_at >= w) begin
      col_at = 0;
      row_at++;
    end
    if (row_at >= h) row_at = 0;
    c = col_at;
    r = row_at;

    column[0] = line_two_up[c];
    column[1] = line_one_up[c];
    column[2] = px;

    if (r >= 2 && c >= 2) begin
      acc = 0;
      for (ky = 0; ky < KDIM; ky++) begin
        for (kx = 0; kx < KDIM; kx++) begin
          p = (kx == 2) ? column[ky] : win_pix[kx*KDIM + ky];
          k = kern_row[ky][kx*COEF_W +: COEF_W];
          acc += longint'(k) * longint'({1'b0, p});
        end
      end
      // truncate toward zero, clamp to the pixel range
      if (acc <= 0) res.pix = '0;
      else if ((acc >>> FRAC_BITS) > 255) res.pix = '1;
      else res.pix = PIX_W'(acc >>> FRAC_BITS);
      res.last = (r == h - 1) && (c == w - 1);
      expected_pix.push_back(res);
    end

    for (kx = 0; kx < KDIM; kx++) begin
      win_pix[kx]        = win_pix[KDIM + kx];
      win_pix[KDIM + kx] = column[kx];
    end
    line_two_up[c] = line_one_up[c];
    line_one_up[c] = px;

    // natural wrap at the end of a row and of a frame
    if (c + 1 >= w) begin
      col_at = 0;
      row_at = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_at = c + 1;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Random helpers
  // --------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_word();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return PIX_W'($urandom);
  endfunction

  function automatic logic [COEF_ROW_W-1:0] rand_kernel_row(input kern_style_t style);
    logic [COEF_ROW_W-1:0] row;
    logic [COEF_W-1:0]     k;
    int                    kx;
    row = '0;
    for (kx = 0; kx < KDIM; kx++) begin
      case (style)
        KERN_SMOOTH: k = COEF_W'($urandom_range(0, 16'h0300));
        KERN_SIGNED: k = COEF_W'($urandom_range(0, 16'h0C00)) - 16'h0600;
        KERN_FULL:   k = COEF_W'($urandom);
        default: begin
          case ($urandom_range(0, 4))
            0:       k = 16'h7FFF;
            1:       k = 16'h8000;
            2:       k = 16'hFFFF;
            3:       k = 16'h0001;
            default: k = 16'h0000;
          endcase
        end
      endcase
      row[kx*COEF_W +: COEF_W] = k;
    end
    return row;
  endfunction

  // --------------------------------------------------------------------------
  // Bus tasks; all of them are entered and left at a falling edge
  // --------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_IMAGE_WIDTH:  geo_width   = val[IMG_W_BITS-1:0];
      REG_IMAGE_HEIGHT: geo_height  = val[IMG_H_BITS-1:0];
      REG_COEF_TOP:     kern_row[0] = val;
      REG_COEF_MID:     kern_row[1] = val;
      REG_COEF_BOT:     kern_row[2] = val;
      default: ;  // unused index, ignored
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_kernel(input kern_style_t style);
    write_reg(REG_COEF_TOP, rand_kernel_row(style));
    write_reg(REG_COEF_MID, rand_kernel_row(style));
    write_reg(REG_COEF_BOT, rand_kernel_row(style));
  endtask

  // one pixel request; valid stays high when the next one follows at once
  task automatic send_pixel(input logic [PIX_W-1:0] px, input logic fs);
    int unsigned gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= px;
    in_tuser  <= fs;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_filtered(px, fs);
    @(negedge clk);
  endtask

  // stop offering, let all results out, then let border pixels settle
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_pix.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Two 4x3 frames. First with the smoothing kernel on a checkerboard, which
  // truncates a .5 result. Second with no frame start (counters wrap) and an
  // extreme kernel: one centre clamps high, the other goes negative.
  task automatic test_directed_frames();
    int i;
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(4));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(3));
    write_reg(REG_COEF_TOP, RST_COEF_EDGE);
    write_reg(REG_COEF_MID, RST_COEF_CENTER);
    write_reg(REG_COEF_BOT, RST_COEF_EDGE);
    for (i = 0; i < 12; i++)
      send_pixel((((i / 4) + i) % 2 == 0) ? 8'hFF : 8'h00, i == 0);
    drain();

    write_reg(REG_COEF_TOP, 48'h8000_8000_8000);
    write_reg(REG_COEF_MID, 48'h0000_7FFF_0000);
    write_reg(REG_COEF_BOT, '0);
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    for (i = 0; i < 12; i++)
      send_pixel((i == 3 || i == 5) ? 8'hFF : 8'h00, 1'b0);
    drain();
  endtask

  // Shrink width, then height, while the counters sit past the new limits.
  task automatic test_geometry_shrink();
    int i;
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(6));
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(8));
    write_kernel(KERN_SMOOTH);
    // three rows and four pixels: parked at row 3, column 4
    for (i = 0; i < 22; i++) send_pixel(rand_pixel(), i == 0);
    drain();
    // column 4 is past width 3, so the next pixel opens row 4
    write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(3));
    for (i = 0; i < 4; i++) send_pixel(rand_pixel(), 1'b0);
    drain();
    // parked at row 5, column 1; row 5 is past height 3, so back to row 0
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(3));
    for (i = 0; i < 17; i++) send_pixel(rand_pixel(), 1'b0);
    drain();
  endtask

  // Saturated geometry: the widest row with minimum height, where a short
  // run of the first row must give nothing, then the narrowest row with the
  // tallest frame for a stack of rows. Unused register indexes are written too.
  task automatic test_geometry_extremes();
    int i;
    int u;
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    write_reg(REG_IMAGE_WIDTH, {(CFG_DATA_W-IMG_W_BITS)'(rand_word() >> IMG_W_BITS),
                                {IMG_W_BITS{1'b1}}});
    write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(3));
    write_kernel(KERN_SIGNED);
    for (u = int'(REG_COEF_BOT) + 1; u < (1 << CFG_IDX_W); u++)
      write_reg(CFG_IDX_W'(u), rand_word());
    for (i = 0; i < WIDE_PIXELS; i++) send_pixel(rand_pixel(), i == 0);
    drain();

    write_reg(REG_IMAGE_WIDTH, '0);
    write_reg(REG_IMAGE_HEIGHT, {IMG_H_BITS{1'b1}});
    write_kernel(KERN_EXTREME);
    for (i = 0; i < TALL_PIXELS; i++) send_pixel(rand_pixel(), i == 0);
    drain();
  endtask

  // Random small frames with random kernels; some frames are cut short by an
  // early frame start. One phase runs under a long receiver hold-off.
  task automatic test_random_frames(input int unsigned item_goal);
    int unsigned sent, w, h, frames, f, i, npix, cut;
    bit          held;
    bit          restart;
    logic [CFG_DATA_W-1:0] word;
    sent = 0;
    held = 1'b0;
    while (sent < item_goal) begin
      drain();
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_gaps_on = ($urandom_range(0, 3) != 0);
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
      h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
      word = rand_word();
      word[IMG_W_BITS-1:0] = IMG_W_BITS'(w);
      write_reg(REG_IMAGE_WIDTH, word);
      word = rand_word();
      word[IMG_H_BITS-1:0] = IMG_H_BITS'(h);
      write_reg(REG_IMAGE_HEIGHT, word);
      write_kernel(kern_style_t'($urandom_range(0, 3)));
      if (w < KDIM) w = KDIM;
      if (h < KDIM) h = KDIM;

      if (!held && sent >= item_goal / 3) begin
        held          = 1'b1;
        tx_gaps_on    = 1'b0;
        hold_requests = hold_requests + 1;
      end

      frames  = $urandom_range(1, 4);
      restart = 1'b1;
      npix    = w * h;
      for (f = 0; f < frames; f++) begin
        cut = ($urandom_range(0, 5) == 0) ? $urandom_range(1, npix - 1) : npix;
        for (i = 0; i < cut; i++) begin
          send_pixel(rand_pixel(), (i == 0) && (restart || $urandom_range(0, 1) == 1));
          sent++;
        end
        restart = (cut != npix);
      end
    end
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Output ready: random stalls, plus a long hold-off on request
  // --------------------------------------------------------------------------
  initial begin : rx_ready_drive
    int unsigned idle_left;
    int unsigned hold_left;
    int unsigned holds_done;
    idle_left  = 0;
    hold_left  = 0;
    holds_done = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != hold_requests) begin
        holds_done = hold_requests;
        hold_left  = LONG_HOLD;
      end
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (idle_left != 0) begin
        out_tready <= 1'b0;
        idle_left--;
      end else begin
        out_tready <= 1'b1;
        if (rx_gaps_on && $urandom_range(0, 2) == 0) idle_left = pick_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result check: one expectation per accepted output request
  // --------------------------------------------------------------------------
  initial begin : result_check
    filt_pix_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (expected_pix.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result, expected none, actual pixel %0d last %0b",
                   $time, out_tdata, out_tlast);
        end else begin
          want = expected_pix.pop_front();
          if (out_tdata !== want.pix) begin
            n_errors++;
            $display("%0t: pixel_out expected %0d, actual %0d", $time, want.pix, out_tdata);
          end
          if (out_tlast !== want.last) begin
            n_errors++;
            $display("%0t: frame_end expected %0b, actual %0b", $time, want.last, out_tlast);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : test_sequence
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    tx_gaps_on    = 1'b0;
    rx_gaps_on    = 1'b0;
    hold_requests = 0;
    n_errors      = 0;
    model_reset();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_frames();
    test_geometry_shrink();
    test_geometry_extremes();
    test_random_frames(RANDOM_ITEMS);

    if (n_errors == 0 && expected_pix.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : run_limit
    #(RUN_LIMIT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

`default_nettype wire
